// ----- design/assert_macros.svh -----
// Concurrent assertion helpers, clocked on the rising edge and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/hfts_pkg.sv -----
package hfts_pkg;

    localparam int COORD_W         = 24;
    localparam int HEIGHT_W        = 24;
    localparam int INDEX_W         = 16;
    localparam int CNT_W           = 9;
    localparam int FRAC_W          = 17;
    localparam int MAX_COLUMNS_DEF = 256;
    localparam int MAX_ROWS_DEF    = 256;
    localparam int UNIT_Q16        = 65536;
    localparam int DEFAULT_HEIGHT  = 48;

    typedef enum logic [2:0] {
        REG_MIN_X   = 3'd0,
        REG_MIN_Y   = 3'd1,
        REG_MAX_X   = 3'd2,
        REG_MAX_Y   = 3'd3,
        REG_COLUMNS = 3'd4,
        REG_ROWS    = 3'd5
    } t_reg_idx;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

    typedef struct packed {
        logic                vld;
        logic                qry;
        logic                dflt;
        logic                wen;
        logic [INDEX_W-1:0]  widx;
        logic [HEIGHT_W-1:0] wdata;
    } t_side;

endpackage

// ----- design/hfts_div.sv -----
module hfts_div #(
    parameter int NW = 33,
    parameter int LW = 8
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [NW-1:0]                 i_n,
    input  logic [hfts_pkg::COORD_W-1:0]  i_ex,
    output logic [LW+15:0]                o_q
);
    import hfts_pkg::*;

    localparam int QW = LW + 16;

    logic [COORD_W-1:0] r_rem  [QW];
    logic [QW-1:0]      r_quo  [QW];
    logic [COORD_W-1:0] rem_in [QW];
    logic [QW-1:0]      quo_in [QW];

    assign rem_in[0] = COORD_W'(i_n >> LW);
    assign quo_in[0] = QW'({i_n, 16'd0});

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [COORD_W:0]   trial;
        logic [COORD_W+1:0] diff;
        logic               take;

        if (k > 0) begin : g_link
            assign rem_in[k] = r_rem[k-1];
            assign quo_in[k] = r_quo[k-1];
        end

        assign trial = {rem_in[k], quo_in[k][QW-1]};
        assign diff  = {1'b0, trial} - {2'b00, i_ex};
        assign take  = !diff[COORD_W+1];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= take ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
                r_quo[k] <= {quo_in[k][QW-2:0], take};
            end
        end
    end

    assign o_q = r_quo[QW-1];

endmodule

// ----- design/heightfield_triangle_sampler.sv -----
// Channel   Dir  Transaction content
// s_axis    in   tuser: req_type; tdata: vertex_index, height_value, point_x, point_y
// m_axis    out  tdata: ground_height
// apb       in   register writes and reads, pready always high
//
// One item per cycle while m_axis does not stall; the divider computes one bit per stage.
// Reset is synchronous and clears the configuration registers and all stage valid bits.
// A stall on m_axis freezes every stage; s_axis_tready follows it directly.
// The vertex store holds two copies, each read at two addresses per cycle.
`include "assert_macros.svh"
module heightfield_triangle_sampler #(
    parameter int MAX_COLUMNS = hfts_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = hfts_pkg::MAX_ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // vertex_index, height_value, point_x, point_y
    input  logic [0:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // ground_height
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hfts_pkg::*;

    localparam int LWX   = $clog2(MAX_COLUMNS);
    localparam int LWY   = $clog2(MAX_ROWS);
    localparam int CNX   = $clog2(MAX_COLUMNS + 1);
    localparam int CNY   = $clog2(MAX_ROWS + 1);
    localparam int LWD   = (LWX > LWY) ? LWX : LWY;
    localparam int QW    = LWD + 16;
    localparam int NWX   = COORD_W + CNX;
    localparam int NWY   = COORD_W + CNY;
    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    logic signed [COORD_W-1:0] r_min_x, r_min_y, r_max_x, r_max_y;
    logic [CNT_W-1:0]          r_cols, r_rows;

    logic en, acc_in;
    logic r_ovalid;
    logic [HEIGHT_W-1:0] r_odata;

    assign en            = !r_ovalid || m_axis_tready;
    assign acc_in        = s_axis_tvalid && en;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign pready        = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '0;
            r_min_y <= '0;
            r_max_x <= '0;
            r_max_y <= '0;
            r_cols  <= '0;
            r_rows  <= '0;
        end else if (psel && penable && pwrite) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_MIN_X:   r_min_x <= pwdata[COORD_W-1:0];
                REG_MIN_Y:   r_min_y <= pwdata[COORD_W-1:0];
                REG_MAX_X:   r_max_x <= pwdata[COORD_W-1:0];
                REG_MAX_Y:   r_max_y <= pwdata[COORD_W-1:0];
                REG_COLUMNS: r_cols  <= pwdata[CNT_W-1:0];
                REG_ROWS:    r_rows  <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_MIN_X:   prdata = {8'd0, r_min_x};
            REG_MIN_Y:   prdata = {8'd0, r_min_y};
            REG_MAX_X:   prdata = {8'd0, r_max_x};
            REG_MAX_Y:   prdata = {8'd0, r_max_y};
            REG_COLUMNS: prdata = {23'd0, r_cols};
            REG_ROWS:    prdata = {23'd0, r_rows};
            default:     prdata = '0;
        endcase
    end

    logic [CNX-1:0]     cols_eff, cm1_x, lim_x;
    logic [CNY-1:0]     rows_eff, cm1_y, lim_y;
    logic [COORD_W:0]   ex_x_w, ex_y_w;
    logic [COORD_W-1:0] ex_x, ex_y;
    logic               dflt;

    assign cols_eff = (32'(r_cols) > 32'(MAX_COLUMNS)) ? CNX'(MAX_COLUMNS) : CNX'(r_cols);
    assign rows_eff = (32'(r_rows) > 32'(MAX_ROWS)) ? CNY'(MAX_ROWS) : CNY'(r_rows);
    assign cm1_x    = cols_eff - CNX'(1);
    assign cm1_y    = rows_eff - CNY'(1);
    assign lim_x    = cols_eff - CNX'(2);
    assign lim_y    = rows_eff - CNY'(2);
    assign ex_x_w   = {r_max_x[COORD_W-1], r_max_x} - {r_min_x[COORD_W-1], r_min_x};
    assign ex_y_w   = {r_max_y[COORD_W-1], r_max_y} - {r_min_y[COORD_W-1], r_min_y};
    assign ex_x     = ex_x_w[COORD_W-1:0];
    assign ex_y     = ex_y_w[COORD_W-1:0];
    assign dflt     = (32'(cols_eff) < 32'd2) || (32'(rows_eff) < 32'd2)
                   || (r_max_x <= r_min_x) || (r_max_y <= r_min_y);

    function automatic logic [COORD_W-1:0] axis_offset(
        input logic signed [COORD_W-1:0] p,
        input logic signed [COORD_W-1:0] lo,
        input logic signed [COORD_W-1:0] hi
    );
        logic signed [COORD_W-1:0] pc;
        logic [COORD_W:0]          d;
        pc = (p < lo) ? lo : ((p > hi) ? hi : p);
        d  = {pc[COORD_W-1], pc} - {lo[COORD_W-1], lo};
        return d[COORD_W-1:0];
    endfunction

    // stage 1: clamp and offset
    t_side              side_in, r_s1_side;
    logic [COORD_W-1:0] r_dx, r_dy;
    logic [INDEX_W-1:0] in_idx;

    assign in_idx = s_axis_tdata[15:0];

    always_comb begin
        side_in.vld   = acc_in;
        side_in.qry   = (t_req'(s_axis_tuser[0]) == REQ_QUERY);
        side_in.dflt  = dflt;
        side_in.wen   = (32'(in_idx) < 32'(DEPTH));
        side_in.widx  = in_idx;
        side_in.wdata = s_axis_tdata[39:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_side <= '0;
        end else if (en) begin
            r_s1_side <= side_in;
            r_dx      <= axis_offset(s_axis_tdata[63:40], r_min_x, r_max_x);
            r_dy      <= axis_offset(s_axis_tdata[87:64], r_min_y, r_max_y);
        end
    end

    // stage 2: scale by cell count
    t_side          r_s2_side;
    logic [NWX-1:0] r_nx;
    logic [NWY-1:0] r_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_side <= '0;
        end else if (en) begin
            r_s2_side <= r_s1_side;
            r_nx      <= NWX'(r_dx) * NWX'(cm1_x);
            r_ny      <= NWY'(r_dy) * NWY'(cm1_y);
        end
    end

    // divider stages
    logic [QW-1:0] q_x, q_y;

    hfts_div #(.NW(NWX), .LW(LWD)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_n   (r_nx),
        .i_ex  (ex_x),
        .o_q   (q_x)
    );

    hfts_div #(.NW(NWY), .LW(LWD)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_n   (r_ny),
        .i_ex  (ex_y),
        .o_q   (q_y)
    );

    t_side r_dv_side [QW];
    t_side dv_in     [QW];

    for (genvar k = 0; k < QW; k++) begin : g_side
        if (k == 0) begin : g_first
            assign dv_in[k] = r_s2_side;
        end else begin : g_next
            assign dv_in[k] = r_dv_side[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_side[k] <= '0;
            end else if (en) begin
                r_dv_side[k] <= dv_in[k];
            end
        end
    end

    // stage C: cell and fraction
    t_side             r_c_side;
    logic [LWX-1:0]    cx_sel, r_cx;
    logic [LWY-1:0]    cy_sel, r_cy;
    logic [QW-1:0]     fx, fy;
    logic [FRAC_W-1:0] r_tx, r_ty;

    assign cx_sel = (32'(q_x[QW-1:16]) > 32'(lim_x)) ? LWX'(lim_x) : LWX'(q_x[QW-1:16]);
    assign cy_sel = (32'(q_y[QW-1:16]) > 32'(lim_y)) ? LWY'(lim_y) : LWY'(q_y[QW-1:16]);
    assign fx     = q_x - (QW'(cx_sel) << 16);
    assign fy     = q_y - (QW'(cy_sel) << 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_side <= '0;
        end else if (en) begin
            r_c_side <= r_dv_side[QW-1];
            r_cx     <= cx_sel;
            r_cy     <= cy_sel;
            r_tx     <= (32'(fx) > 32'(UNIT_Q16)) ? FRAC_W'(UNIT_Q16) : FRAC_W'(fx);
            r_ty     <= (32'(fy) > 32'(UNIT_Q16)) ? FRAC_W'(UNIT_Q16) : FRAC_W'(fy);
        end
    end

    // stage D: base address and triangle weights
    t_side             r_d_side;
    logic [AW-1:0]     r_a;
    logic              r_d_lower;
    logic [FRAC_W-1:0] r_w1, r_w2, r_w3;
    logic [FRAC_W:0]   tsum;
    logic              lower;

    assign tsum  = {1'b0, r_tx} + {1'b0, r_ty};
    assign lower = (tsum <= (FRAC_W+1)'(UNIT_Q16));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_side <= '0;
        end else if (en) begin
            r_d_side  <= r_c_side;
            r_a       <= AW'(32'(r_cy) * 32'(cols_eff) + 32'(r_cx));
            r_d_lower <= lower;
            r_w1      <= lower ? FRAC_W'((FRAC_W+1)'(UNIT_Q16) - tsum)
                               : FRAC_W'(tsum - (FRAC_W+1)'(UNIT_Q16));
            r_w2      <= lower ? r_tx : FRAC_W'(UNIT_Q16) - r_ty;
            r_w3      <= lower ? r_ty : FRAC_W'(UNIT_Q16) - r_tx;
        end
    end

    // stage E: vertex store, two copies
    logic signed [HEIGHT_W-1:0] r_mem_a [DEPTH];
    logic signed [HEIGHT_W-1:0] r_mem_b [DEPTH];
    logic [AW-1:0]              ra1, rb0, rb1;
    logic                       wr;
    t_side                      r_e_side;
    logic                       r_e_lower;
    logic [FRAC_W-1:0]          r_e_w1, r_e_w2, r_e_w3;
    logic signed [HEIGHT_W-1:0] r_za, r_zb, r_zc, r_zd;

    assign ra1 = AW'(32'(r_a) + 32'd1);
    assign rb0 = AW'(32'(r_a) + 32'(cols_eff));
    assign rb1 = AW'(32'(r_a) + 32'(cols_eff) + 32'd1);
    assign wr  = en && r_d_side.vld && !r_d_side.qry && r_d_side.wen;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem_a[AW'(r_d_side.widx)] <= r_d_side.wdata;
        end
        if (en) begin
            r_za <= r_mem_a[r_a];
            r_zb <= r_mem_a[ra1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem_b[AW'(r_d_side.widx)] <= r_d_side.wdata;
        end
        if (en) begin
            r_zc <= r_mem_b[rb0];
            r_zd <= r_mem_b[rb1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_side <= '0;
        end else if (en) begin
            r_e_side  <= r_d_side;
            r_e_lower <= r_d_lower;
            r_e_w1    <= r_w1;
            r_e_w2    <= r_w2;
            r_e_w3    <= r_w3;
        end
    end

    // stage F: weighted products
    t_side                      r_f_side;
    logic signed [HEIGHT_W-1:0] h1;
    logic signed [41:0]         r_m1, r_m2, r_m3;

    assign h1 = r_e_lower ? r_za : r_zd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_side <= '0;
        end else if (en) begin
            r_f_side <= r_e_side;
            r_m1     <= h1   * $signed({1'b0, r_e_w1});
            r_m2     <= r_zb * $signed({1'b0, r_e_w2});
            r_m3     <= r_zc * $signed({1'b0, r_e_w3});
        end
    end

    // output: round, saturate
    localparam logic signed [27:0] HMAX = 28'sd8388607;
    localparam logic signed [27:0] HMIN = -28'sd8388608;

    logic signed [43:0]         acc;
    logic signed [27:0]         qv;
    logic [HEIGHT_W-1:0]        sat;

    assign acc = {{2{r_m1[41]}}, r_m1} + {{2{r_m2[41]}}, r_m2} + {{2{r_m3[41]}}, r_m3}
               + 44'sd32768;
    assign qv  = acc[43:16];
    assign sat = (qv > HMAX) ? HEIGHT_W'(HMAX) : ((qv < HMIN) ? HEIGHT_W'(HMIN)
                                                              : HEIGHT_W'(qv));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_ovalid <= r_f_side.vld && r_f_side.qry;
            r_odata  <= r_f_side.dflt ? HEIGHT_W'(DEFAULT_HEIGHT) : sat;
        end
    end

    `ASSERT_HOLDS(a_weight_sum, i_clk, i_rst_n, r_d_side.vld |-> ((FRAC_W+1)'(r_w1) + (FRAC_W+1)'(r_w2) + (FRAC_W+1)'(r_w3) == (FRAC_W+1)'(UNIT_Q16)))
    `ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, en && r_f_side.vld && !r_f_side.qry, !m_axis_tvalid)
    `ASSERT_NEXT(a_default_height, i_clk, i_rst_n, en && r_f_side.vld && r_f_side.qry && r_f_side.dflt, m_axis_tvalid && (m_axis_tdata == HEIGHT_W'(DEFAULT_HEIGHT)))

endmodule
